>>> design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the checker file of the value stack.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion that is switched off while the active-low reset is held.
`define USK_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Clocked assertion that is also checked while reset is held.
`define USK_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> design/usk_pkg.sv
// ----------------------------------------------------------------------------
// usk_pkg
// Types and codes shared by the value stack with undo history.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package usk_pkg;

    localparam int VALUE_W = 32;

    typedef enum logic [1:0] {
        MODE_PUSH = 2'd0,
        MODE_PEEK = 2'd1,
        MODE_POP  = 2'd2,
        MODE_UNDO = 2'd3
    } t_mode;

    typedef enum logic [1:0] {
        ST_OK      = 2'd0,
        ST_EMPTY   = 2'd1,
        ST_NO_UNDO = 2'd2,
        ST_FULL    = 2'd3
    } t_status;

    typedef enum logic [1:0] {
        UNDONE_NONE = 2'd0,
        UNDONE_PUSH = 2'd1,
        UNDONE_POP  = 2'd2
    } t_undone;

    // Kind bit of a history entry.
    localparam logic KIND_PUSH = 1'b0;
    localparam logic KIND_POP  = 1'b1;

    typedef enum logic [1:0] {
        STK_HOLD = 2'd0,
        STK_PUSH = 2'd1,
        STK_POP  = 2'd2
    } t_stk_op;

    typedef enum logic [1:0] {
        HIST_HOLD = 2'd0,
        HIST_LOG  = 2'd1,
        HIST_UNDO = 2'd2
    } t_hist_op;

    typedef struct packed {
        t_stk_op            op;
        logic [VALUE_W-1:0] data;
    } t_stk_ctrl;

    typedef struct packed {
        logic               empty;
        logic               full;
        logic [VALUE_W-1:0] top;
    } t_stk_stat;

    typedef struct packed {
        t_hist_op           op;
        logic               kind;
        logic [VALUE_W-1:0] data;
    } t_hist_ctrl;

    typedef struct packed {
        logic               empty;
        logic               kind;
        logic [VALUE_W-1:0] value;
    } t_hist_stat;

endpackage

>>> design/usk_ram.sv
// ----------------------------------------------------------------------------
// usk_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module usk_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                 i_clk,
    input  logic                                 i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                     i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                     o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // A read at the address being written returns the old contents.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> design/usk_stack.sv
// ----------------------------------------------------------------------------
// usk_stack
// Value stack: the top two entries are held in registers, the whole stack
// is mirrored in a RAM that keeps the entry below them prefetched.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module usk_stack #(
    parameter int DEPTH = 16
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  usk_pkg::t_stk_ctrl i_ctrl,
    output usk_pkg::t_stk_stat o_stat
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    logic [CW-1:0]               r_count, n_count;
    logic [usk_pkg::VALUE_W-1:0] r_top, n_top;
    logic [usk_pkg::VALUE_W-1:0] r_second, n_second;
    logic [usk_pkg::VALUE_W-1:0] rd_data;
    logic                        ram_we;
    logic [AW-1:0]               ram_raddr;

    always_comb begin
        n_count  = r_count;
        n_top    = r_top;
        n_second = r_second;
        ram_we   = 1'b0;
        unique case (i_ctrl.op)
            usk_pkg::STK_PUSH: begin
                n_count  = r_count + 1'b1;
                n_top    = i_ctrl.data;
                n_second = r_top;
                ram_we   = 1'b1;
            end
            usk_pkg::STK_POP: begin
                n_count  = r_count - 1'b1;
                n_top    = r_second;
                n_second = rd_data;
            end
            default: begin
            end
        endcase
    end

    // The read issued now returns the third entry from the top of the stack
    // as it stands in the next cycle, ready for a pop there.
    assign ram_raddr = AW'(n_count - CW'(3));

    usk_ram #(
        .WIDTH(usk_pkg::VALUE_W),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(r_count[AW-1:0]),
        .i_wdata(i_ctrl.data),
        .i_raddr(ram_raddr),
        .o_rdata(rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top    <= n_top;
        r_second <= n_second;
    end

    assign o_stat.empty = (r_count == '0);
    assign o_stat.full  = (r_count == CW'(DEPTH));
    assign o_stat.top   = r_top;

endmodule

>>> design/usk_hist.sv
// ----------------------------------------------------------------------------
// usk_hist
// Undo history: a ring of logged operations that drops its oldest entry when
// full. The two newest entries are held in registers, the ring in a RAM.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module usk_hist #(
    parameter int DEPTH = 16
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  usk_pkg::t_hist_ctrl i_ctrl,
    output usk_pkg::t_hist_stat o_stat
);

    localparam int CW = $clog2(DEPTH + 1);
    localparam int IW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int EW = usk_pkg::VALUE_W + 1;

    logic [IW-1:0] r_newest, n_newest;
    logic [CW-1:0] r_count, n_count;
    logic [EW-1:0] r_h0, n_h0;
    logic [EW-1:0] r_h1, n_h1;
    logic [EW-1:0] rd_data;
    logic [EW-1:0] log_entry;
    logic [IW-1:0] idx_next;
    logic          ram_we;

    function automatic logic [IW-1:0] f_dec(input logic [IW-1:0] a);
        return (a == '0) ? IW'(DEPTH - 1) : a - 1'b1;
    endfunction

    assign idx_next  = (r_newest == IW'(DEPTH - 1)) ? '0 : r_newest + 1'b1;
    assign log_entry = {i_ctrl.kind, i_ctrl.data};

    always_comb begin
        n_newest = r_newest;
        n_count  = r_count;
        n_h0     = r_h0;
        n_h1     = r_h1;
        ram_we   = 1'b0;
        unique case (i_ctrl.op)
            usk_pkg::HIST_LOG: begin
                n_newest = idx_next;
                n_count  = (r_count == CW'(DEPTH)) ? r_count : r_count + 1'b1;
                n_h0     = log_entry;
                n_h1     = r_h0;
                ram_we   = 1'b1;
            end
            usk_pkg::HIST_UNDO: begin
                n_newest = f_dec(r_newest);
                n_count  = r_count - 1'b1;
                n_h0     = r_h1;
                n_h1     = rd_data;
            end
            default: begin
            end
        endcase
    end

    usk_ram #(
        .WIDTH(EW),
        .DEPTH(DEPTH)
    ) u_ram (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(idx_next),
        .i_wdata(log_entry),
        .i_raddr(f_dec(f_dec(n_newest))),
        .o_rdata(rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_newest <= '0;
            r_count  <= '0;
        end else begin
            r_newest <= n_newest;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_h0 <= n_h0;
        r_h1 <= n_h1;
    end

    assign o_stat.empty = (r_count == '0);
    assign o_stat.kind  = r_h0[EW-1];
    assign o_stat.value = r_h0[usk_pkg::VALUE_W-1:0];

endmodule

>>> design/undoable_stack.sv
// ----------------------------------------------------------------------------
// undoable_stack
// Value stack of signed 32-bit numbers with push, peek, pop and undo.
// ----------------------------------------------------------------------------
// Commands arrive on the s_axis stream: the operation code in tuser and the
// value to push in tdata. Every command beat gives exactly one result beat on
// the m_axis stream: status and undone kind in tuser, the value in tdata.
// A command passes an input register and then a result register before its
// result beat is offered. One command is taken every cycle while the receiver
// keeps tready high: the stack and the history each keep their two newest
// entries in registers, and their RAMs prefetch the entry below, so no command
// waits for a RAM read.
// A push onto a full stack and a pop from an empty stack are refused and
// logged nowhere. When the history is full the oldest entry is dropped.
// Synchronous reset empties the stack and the history and discards any beat
// in flight; there is no clearing pass. While the receiver holds tready low,
// the result beat waits in the result register and one more command can be
// taken into the input register before s_axis_tready falls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module undoable_stack #(
    parameter int STACK_DEPTH   = 16,
    parameter int HISTORY_DEPTH = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] value
    input  logic [1:0]  s_axis_tuser,   // [1:0] mode
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [31:0] result_value
    output logic [3:0]  m_axis_tuser    // [1:0] status, [3:2] undone_kind
);

    logic                 r_in_valid, n_in_valid;
    usk_pkg::t_mode       r_mode;
    logic signed [31:0]   r_value;

    logic                 r_out_valid, n_out_valid;
    usk_pkg::t_status     r_status, res_status;
    logic signed [31:0]   r_result, res_value;
    usk_pkg::t_undone     r_kind, res_kind;

    logic                 in_beat;
    logic                 proc;

    usk_pkg::t_stk_ctrl   stk_ctrl, stk_req;
    usk_pkg::t_stk_stat   stk_stat;
    usk_pkg::t_hist_ctrl  hist_ctrl, hist_req;
    usk_pkg::t_hist_stat  hist_stat;

    assign proc          = r_in_valid && (!r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_in_valid || proc;
    assign in_beat       = s_axis_tvalid && s_axis_tready;

    // Command decode against the current stack and history state.
    always_comb begin
        stk_req.op     = usk_pkg::STK_HOLD;
        stk_req.data   = r_value;
        hist_req.op    = usk_pkg::HIST_HOLD;
        hist_req.kind  = usk_pkg::KIND_PUSH;
        hist_req.data  = r_value;
        res_status     = usk_pkg::ST_OK;
        res_value      = '0;
        res_kind       = usk_pkg::UNDONE_NONE;
        unique case (r_mode)
            usk_pkg::MODE_PUSH: begin
                if (stk_stat.full) begin
                    res_status = usk_pkg::ST_FULL;
                end else begin
                    stk_req.op  = usk_pkg::STK_PUSH;
                    hist_req.op = usk_pkg::HIST_LOG;
                    res_value   = r_value;
                end
            end
            usk_pkg::MODE_PEEK: begin
                if (stk_stat.empty) begin
                    res_status = usk_pkg::ST_EMPTY;
                end else begin
                    res_value = stk_stat.top;
                end
            end
            usk_pkg::MODE_POP: begin
                if (stk_stat.empty) begin
                    res_status = usk_pkg::ST_EMPTY;
                end else begin
                    stk_req.op    = usk_pkg::STK_POP;
                    hist_req.op   = usk_pkg::HIST_LOG;
                    hist_req.kind = usk_pkg::KIND_POP;
                    hist_req.data = stk_stat.top;
                    res_value     = stk_stat.top;
                end
            end
            usk_pkg::MODE_UNDO: begin
                if (hist_stat.empty) begin
                    res_status = usk_pkg::ST_NO_UNDO;
                end else begin
                    // The history entry is consumed even if it cannot be applied.
                    hist_req.op = usk_pkg::HIST_UNDO;
                    if (hist_stat.kind == usk_pkg::KIND_POP) begin
                        if (stk_stat.full) begin
                            res_status = usk_pkg::ST_FULL;
                        end else begin
                            stk_req.op   = usk_pkg::STK_PUSH;
                            stk_req.data = hist_stat.value;
                            res_value    = hist_stat.value;
                            res_kind     = usk_pkg::UNDONE_POP;
                        end
                    end else begin
                        if (stk_stat.empty) begin
                            res_status = usk_pkg::ST_EMPTY;
                        end else begin
                            stk_req.op = usk_pkg::STK_POP;
                            res_value  = stk_stat.top;
                            res_kind   = usk_pkg::UNDONE_PUSH;
                        end
                    end
                end
            end
        endcase
    end

    always_comb begin
        stk_ctrl  = stk_req;
        hist_ctrl = hist_req;
        if (!proc) begin
            stk_ctrl.op  = usk_pkg::STK_HOLD;
            hist_ctrl.op = usk_pkg::HIST_HOLD;
        end
    end

    usk_stack #(
        .DEPTH(STACK_DEPTH)
    ) u_stack (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctrl (stk_ctrl),
        .o_stat (stk_stat)
    );

    usk_hist #(
        .DEPTH(HISTORY_DEPTH)
    ) u_hist (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_ctrl (hist_ctrl),
        .o_stat (hist_stat)
    );

    always_comb begin
        n_in_valid = r_in_valid;
        if (in_beat) begin
            n_in_valid = 1'b1;
        end else if (proc) begin
            n_in_valid = 1'b0;
        end
        n_out_valid = r_out_valid;
        if (proc) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_mode  <= usk_pkg::t_mode'(s_axis_tuser);
            r_value <= s_axis_tdata;
        end
        if (proc) begin
            r_status <= res_status;
            r_result <= res_value;
            r_kind   <= res_kind;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_result;
    assign m_axis_tuser  = {r_kind, r_status};

endmodule

>>> design/usk_checker.sv
// ----------------------------------------------------------------------------
// usk_checker
// Port-level checks for the value stack, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module usk_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic [31:0] s_axis_tdata,
    input logic [1:0]  s_axis_tuser,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [31:0] m_axis_tdata,
    input logic [3:0]  m_axis_tuser
);

    // A stalled result beat stays offered and unchanged.
    `USK_ASSERT(a_stall_hold, i_clk, i_rst_n, (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)), "stalled result beat changed")

    // Every refused operation reports a zero value.
    `USK_ASSERT(a_err_zero, i_clk, i_rst_n, (m_axis_tvalid && (m_axis_tuser[1:0] != usk_pkg::ST_OK)) |-> (m_axis_tdata == '0), "error result carries a value")

    // An undone kind is only reported with a successful status.
    `USK_ASSERT(a_kind_ok, i_clk, i_rst_n, (m_axis_tvalid && (m_axis_tuser[3:2] != usk_pkg::UNDONE_NONE)) |-> ((m_axis_tuser[1:0] == usk_pkg::ST_OK) && (m_axis_tuser[3:2] != 2'd3)), "undone kind without success")

    // With the result register empty the block always takes a command.
    `USK_ASSERT(a_ready_free, i_clk, i_rst_n, !m_axis_tvalid |-> s_axis_tready, "command refused with result register empty")

    // Reset discards any pending result.
    `USK_ASSERT_ALWAYS(a_rst_clear, i_clk, !i_rst_n |=> !m_axis_tvalid, "result valid after reset")

endmodule

bind undoable_stack usk_checker u_usk_checker (.*);
